// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: operation and status
// codes, sequencer states, default sizes and stream field widths.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int WORD_WIDTH_DEFAULT = 32;

  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int OP_W     = 2;

  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 8;
  localparam int M_DATA_W = 104;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TOP    = 2'd0,
    OP_PUSH_BOTTOM = 2'd1,
    OP_POP_TOP     = 2'd2,
    OP_POP_BOTTOM  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } state_t;

endpackage

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of words in a ring of slots held in one RAM.
// ----------------------------------------------------------------------------
// Each request pushes or pops at the top or the bottom end and returns one
// result: popped word, status, the words now at both ends and the item count.
// The end words are kept in registers beside the slot RAM. A push, a refused
// request and a pop that empties the queue give their result in the cycle
// after acceptance; the result of a pop that leaves words behind waits on
// the registered slot RAM read that refreshes the new end word. Outside that
// read, a new request is taken once the previous result has left or leaves
// in the same cycle. The slot RAM needs no clearing after reset.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // [31:0] data_word
  input  logic [S_USER_W-1:0] s_axis_tuser,  // [1:0] operation, [7:2] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // [31:0] popped_word, [33:32] status,
                                             // [65:34] top_word, [97:66] bottom_word,
                                             // [102:98] item_count, [103] zero
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]      occupancy, occupancy_next;
  logic [IDX_W-1:0]      top_index, top_index_next;
  logic [IDX_W-1:0]      bottom_index, bottom_index_next;
  logic [WORD_WIDTH-1:0] top_cache, top_cache_next;
  logic [WORD_WIDTH-1:0] bottom_cache, bottom_cache_next;
  logic                  fetch_top, fetch_top_next;
  logic                  out_valid, out_valid_next;
  logic [FIELD_W-1:0]    out_popped, out_popped_next;
  status_t               out_status, out_status_next;

  logic                  accept;
  op_t                   op;
  logic                  full;
  logic                  empty;
  logic                  need_fetch;
  logic [IDX_W-1:0]      top_prev, top_fwd, bottom_prev, bottom_fwd;
  logic [WORD_WIDTH-1:0] word_in;
  logic [WORD_WIDTH+FIELD_W-1:0] word_wide;
  logic [WORD_WIDTH+FIELD_W-1:0] top_wide, bottom_wide;
  logic [CNT_W+COUNT_W-1:0]      count_wide;
  logic [FIELD_W-1:0]    top_field, bottom_field;
  logic [FIELD_W-1:0]    top_out, bottom_out;

  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  assign op     = op_t'(s_axis_tuser[OP_W-1:0]);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = (occupancy == CNT_W'(DEPTH));
  assign empty  = (occupancy == '0);

  assign word_wide = {{WORD_WIDTH{1'b0}}, s_axis_tdata[FIELD_W-1:0]};
  assign word_in   = word_wide[WORD_WIDTH-1:0];

  assign top_wide     = {{FIELD_W{1'b0}}, top_cache};
  assign bottom_wide  = {{FIELD_W{1'b0}}, bottom_cache};
  assign top_field    = top_wide[FIELD_W-1:0];
  assign bottom_field = bottom_wide[FIELD_W-1:0];
  assign top_out      = empty ? '0 : top_field;
  assign bottom_out   = empty ? '0 : bottom_field;
  assign count_wide   = {{COUNT_W{1'b0}}, occupancy};

  assign top_prev    = (top_index == '0) ? IDX_W'(DEPTH - 1) : top_index - IDX_W'(1);
  assign top_fwd     = (top_index == IDX_W'(DEPTH - 1)) ? '0 : top_index + IDX_W'(1);
  assign bottom_prev = (bottom_index == '0) ? IDX_W'(DEPTH - 1) : bottom_index - IDX_W'(1);
  assign bottom_fwd  = (bottom_index == IDX_W'(DEPTH - 1)) ? '0 : bottom_index + IDX_W'(1);

  deq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (word_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    occupancy_next    = occupancy;
    top_index_next    = top_index;
    bottom_index_next = bottom_index;
    top_cache_next    = top_cache;
    bottom_cache_next = bottom_cache;
    fetch_top_next    = fetch_top;
    out_valid_next    = out_valid && !m_axis_tready;
    out_popped_next   = out_popped;
    out_status_next   = out_status;
    wr_en             = 1'b0;
    wr_addr           = top_index;
    rd_en             = 1'b0;
    rd_addr           = top_index;
    need_fetch        = 1'b0;

    if (state == S_FETCH) begin
      if (fetch_top) begin
        top_cache_next = rd_data;
      end else begin
        bottom_cache_next = rd_data;
      end
      out_valid_next = 1'b1;
    end

    if (accept) begin
      out_popped_next = '0;
      out_status_next = ST_DONE;
      unique case (op)
        OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
          out_valid_next = 1'b1;
          if (full) begin
            out_status_next = ST_FULL;
          end else if (empty) begin
            wr_en             = 1'b1;
            wr_addr           = (op == OP_PUSH_TOP) ? top_index : bottom_index;
            top_index_next    = wr_addr;
            bottom_index_next = wr_addr;
            top_cache_next    = word_in;
            bottom_cache_next = word_in;
            occupancy_next    = CNT_W'(1);
          end else if (op == OP_PUSH_TOP) begin
            wr_en          = 1'b1;
            wr_addr        = top_fwd;
            top_index_next = top_fwd;
            top_cache_next = word_in;
            occupancy_next = occupancy + CNT_W'(1);
          end else begin
            wr_en             = 1'b1;
            wr_addr           = bottom_prev;
            bottom_index_next = bottom_prev;
            bottom_cache_next = word_in;
            occupancy_next    = occupancy + CNT_W'(1);
          end
        end
        OP_POP_TOP, OP_POP_BOTTOM: begin
          if (empty) begin
            out_status_next = ST_EMPTY;
            out_valid_next  = 1'b1;
          end else begin
            out_popped_next = (op == OP_POP_TOP) ? top_field : bottom_field;
            occupancy_next  = occupancy - CNT_W'(1);
            if (occupancy == CNT_W'(1)) begin
              out_valid_next = 1'b1;
            end else begin
              need_fetch     = 1'b1;
              rd_en          = 1'b1;
              fetch_top_next = (op == OP_POP_TOP);
              if (op == OP_POP_TOP) begin
                rd_addr        = top_prev;
                top_index_next = top_prev;
              end else begin
                rd_addr           = bottom_fwd;
                bottom_index_next = bottom_fwd;
              end
            end
          end
        end
        default: begin
          out_valid_next = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && need_fetch) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
    m_axis_tvalid = out_valid;
    m_axis_tdata  = {1'b0, count_wide[COUNT_W-1:0], bottom_out, top_out,
                     out_status, out_popped};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      occupancy    <= '0;
      top_index    <= '0;
      bottom_index <= '0;
      out_valid    <= 1'b0;
      fetch_top    <= 1'b0;
    end else begin
      state        <= state_next;
      occupancy    <= occupancy_next;
      top_index    <= top_index_next;
      bottom_index <= bottom_index_next;
      out_valid    <= out_valid_next;
      fetch_top    <= fetch_top_next;
    end
  end

  always_ff @(posedge clk) begin
    top_cache    <= top_cache_next;
    bottom_cache <= bottom_cache_next;
    out_popped   <= out_popped_next;
    out_status   <= out_status_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(DEPTH))
    else $error("occupancy exceeds depth");

  a_fetch_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> !m_axis_tvalid && !s_axis_tready)
    else $error("result or request during slot fetch");

  a_fetch_completes: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |=> m_axis_tvalid && state == S_IDLE)
    else $error("slot fetch did not produce a result");

  a_refused_push: assert property (@(posedge clk) disable iff (rst)
    accept && full && (op == OP_PUSH_TOP || op == OP_PUSH_BOTTOM)
      |=> $stable(occupancy) && $stable(top_index) && $stable(bottom_index))
    else $error("refused push changed the queue");

endmodule

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
